@@ sv/psd_pkg.sv @@
// Package for the point-to-segment distance block: payload words,
// region codes and default sizes. No dependencies.
`default_nettype none

package psd_pkg;

    // Default sizes handed to the top-level parameters
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Fixed field widths of the channel words
    localparam int COORD_W = 16;
    localparam int DIST_W  = 25;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Nearest-part codes
    typedef logic [1:0] t_region;
    localparam t_region REGION_START = 2'd0;
    localparam t_region REGION_END   = 2'd1;
    localparam t_region REGION_MID   = 2'd2;

    // Input word
    typedef struct packed {
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_start_z;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic signed [COORD_W-1:0] seg_end_z;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in;

    // Result word
    typedef struct packed {
        logic [DIST_W-1:0] distance_q8;
        t_region           nearest_region;
    } t_out;

endpackage

`default_nettype wire

@@ sv/psd_front.sv @@
// Front end: differences, products, region decision and the dividend/divisor
// for the divider chain. Five register stages. Depends on psd_pkg.
`default_nettype none

module psd_front import psd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int RW = 2*COORD_BITS + 2,
    localparam int QW = 2*COORD_BITS + 2*FRAC_BITS + 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire t_in           i_data,
    output logic               o_valid,
    output logic [RW-1:0]      o_rem,
    output logic [QW-1:0]      o_nq,
    output logic [RW-1:0]      o_div,
    output t_region            o_region
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int PW  = 2*C + 2;
    localparam int TW  = 2*C + 3;
    localparam int FW  = 2*C + 2;
    localparam int MW  = 2*C + 1;
    localparam int SQW = 2*MW;
    localparam int F2W = 4*C + 4;
    localparam int NW  = F2W + 2*FRAC_BITS;

    // ---------------- stage 1: coordinate differences
    logic signed [C-1:0]  x1, y1, z1, x2, y2, z2, x0, y0, z0;
    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_ux, r1_uy, r1_uz, r1_wx, r1_wy, r1_wz;
    logic                 r1_v;

    always_comb begin
        x1 = C'(i_data.seg_start_x);
        y1 = C'(i_data.seg_start_y);
        z1 = C'(i_data.seg_start_z);
        x2 = C'(i_data.seg_end_x);
        y2 = C'(i_data.seg_end_y);
        z2 = C'(i_data.seg_end_z);
        x0 = C'(i_data.point_x);
        y0 = C'(i_data.point_y);
        z0 = C'(i_data.point_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a  <= DW'(x2) - DW'(x1);
            r1_b  <= DW'(y2) - DW'(y1);
            r1_c  <= DW'(z2) - DW'(z1);
            r1_ux <= DW'(x0) - DW'(x1);
            r1_uy <= DW'(y0) - DW'(y1);
            r1_uz <= DW'(z0) - DW'(z1);
            r1_wx <= DW'(x2) - DW'(x0);
            r1_wy <= DW'(y2) - DW'(y0);
            r1_wz <= DW'(z2) - DW'(z0);
        end
    end

    // ---------------- stage 2: all small products
    logic signed [PW-1:0] r2_aa, r2_bb, r2_cc, r2_ta, r2_tb, r2_tc;
    logic signed [PW-1:0] r2_cuy, r2_buz, r2_auz, r2_cux, r2_bux, r2_auy;
    logic signed [PW-1:0] r2_sx, r2_sy, r2_sz, r2_ex, r2_ey, r2_ez;
    logic                 r2_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_aa  <= PW'(r1_a) * PW'(r1_a);
            r2_bb  <= PW'(r1_b) * PW'(r1_b);
            r2_cc  <= PW'(r1_c) * PW'(r1_c);
            r2_ta  <= PW'(r1_a) * PW'(r1_ux);
            r2_tb  <= PW'(r1_b) * PW'(r1_uy);
            r2_tc  <= PW'(r1_c) * PW'(r1_uz);
            r2_cuy <= PW'(r1_c) * PW'(r1_uy);
            r2_buz <= PW'(r1_b) * PW'(r1_uz);
            r2_auz <= PW'(r1_a) * PW'(r1_uz);
            r2_cux <= PW'(r1_c) * PW'(r1_ux);
            r2_bux <= PW'(r1_b) * PW'(r1_ux);
            r2_auy <= PW'(r1_a) * PW'(r1_uy);
            r2_sx  <= PW'(r1_ux) * PW'(r1_ux);
            r2_sy  <= PW'(r1_uy) * PW'(r1_uy);
            r2_sz  <= PW'(r1_uz) * PW'(r1_uz);
            r2_ex  <= PW'(r1_wx) * PW'(r1_wx);
            r2_ey  <= PW'(r1_wy) * PW'(r1_wy);
            r2_ez  <= PW'(r1_wz) * PW'(r1_wz);
        end
    end

    // ---------------- stage 3: squared length, projection, cross product, endpoint d2
    logic [RW-1:0]        r3_r2, r3_d2s, r3_d2e;
    logic signed [TW-1:0] r3_t;
    logic signed [FW-1:0] r3_fx, r3_fy, r3_fz;
    logic                 r3_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_r2  <= $unsigned(r2_aa) + $unsigned(r2_bb) + $unsigned(r2_cc);
            r3_t   <= TW'(r2_ta) + TW'(r2_tb) + TW'(r2_tc);
            r3_fx  <= r2_cuy - r2_buz;
            r3_fy  <= r2_auz - r2_cux;
            r3_fz  <= r2_bux - r2_auy;
            r3_d2s <= $unsigned(r2_sx) + $unsigned(r2_sy) + $unsigned(r2_sz);
            r3_d2e <= $unsigned(r2_ex) + $unsigned(r2_ey) + $unsigned(r2_ez);
        end
    end

    // ---------------- stage 4: region decision, cross squares
    logic [MW-1:0]  mx, my, mz;
    t_region        n4_region;
    logic [SQW-1:0] r4_sqx, r4_sqy, r4_sqz;
    logic [RW-1:0]  r4_r2, r4_d2;
    t_region        r4_region;
    logic           r4_v;

    always_comb begin
        mx = r3_fx[FW-1] ? MW'(-r3_fx) : MW'(r3_fx);
        my = r3_fy[FW-1] ? MW'(-r3_fy) : MW'(r3_fy);
        mz = r3_fz[FW-1] ? MW'(-r3_fz) : MW'(r3_fz);
        // zero-length segment falls to the first endpoint
        if (r3_t[TW-1] || (r3_r2 == '0)) begin
            n4_region = REGION_START;
        end else if (r3_t > $signed({1'b0, r3_r2})) begin
            n4_region = REGION_END;
        end else begin
            n4_region = REGION_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sqx    <= SQW'(mx) * SQW'(mx);
            r4_sqy    <= SQW'(my) * SQW'(my);
            r4_sqz    <= SQW'(mz) * SQW'(mz);
            r4_r2     <= r3_r2;
            r4_d2     <= (n4_region == REGION_END) ? r3_d2e : r3_d2s;
            r4_region <= n4_region;
        end
    end

    // ---------------- stage 5: dividend and divisor
    // endpoints divide by one so both cases share the divider chain
    logic [F2W-1:0] f2;
    logic [NW-1:0]  n5_num;
    logic [RW-1:0]  n5_div;

    always_comb begin
        f2 = F2W'(r4_sqx) + F2W'(r4_sqy) + F2W'(r4_sqz);
        if (r4_region == REGION_MID) begin
            n5_num = NW'(f2) << (2*FRAC_BITS);
            n5_div = r4_r2;
        end else begin
            n5_num = NW'(r4_d2) << (2*FRAC_BITS);
            n5_div = RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem    <= n5_num[NW-1:QW];
            o_nq     <= n5_num[QW-1:0];
            o_div    <= n5_div;
            o_region <= r4_region;
        end
    end

    // ---------------- stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            o_valid <= r4_v;
        end
    end

endmodule

`default_nettype wire

@@ sv/psd_div_cell.sv @@
// One restoring-division cell: brings in one dividend bit, makes one
// quotient bit, hands the result to the next cell. Depends on psd_pkg.
`default_nettype none

module psd_div_cell import psd_pkg::*; #(
    parameter int RW = 34,
    parameter int QW = 50
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [QW-1:0] i_nq,
    input  wire logic [RW-1:0] i_div,
    input  wire t_region       i_region,
    output logic               o_valid,
    output logic [RW-1:0]      o_rem,
    output logic [QW-1:0]      o_nq,
    output logic [RW-1:0]      o_div,
    output t_region            o_region
);

    logic [RW:0]   trial;
    logic          ge;
    logic [RW-1:0] n_rem;

    // compare-subtract; quotient bit shifts in as dividend bit shifts out
    always_comb begin
        trial = {i_rem, i_nq[QW-1]};
        ge    = (trial >= {1'b0, i_div});
        n_rem = ge ? RW'(trial - {1'b0, i_div}) : trial[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem    <= n_rem;
            o_nq     <= {i_nq[QW-2:0], ge};
            o_div    <= i_div;
            o_region <= i_region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule

`default_nettype wire

@@ sv/psd_sqrt_cell.sv @@
// One restoring square-root cell: takes two radicand bits, makes one root
// bit, hands the result to the next cell. Depends on psd_pkg.
`default_nettype none

module psd_sqrt_cell import psd_pkg::*; #(
    parameter int SW = 25
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [SW:0]     i_rem,
    input  wire logic [SW-1:0]   i_root,
    input  wire logic [2*SW-1:0] i_rad,
    input  wire t_region         i_region,
    output logic                 o_valid,
    output logic [SW:0]          o_rem,
    output logic [SW-1:0]        o_root,
    output logic [2*SW-1:0]      o_rad,
    output t_region              o_region
);

    logic [SW+2:0] acc;
    logic [SW+2:0] trial;
    logic          ge;

    // try root*4+1 against the running remainder
    always_comb begin
        acc   = {i_rem, i_rad[2*SW-1 -: 2]};
        trial = {1'b0, i_root, 2'b01};
        ge    = (acc >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem    <= ge ? (SW+1)'(acc - trial) : acc[SW:0];
            o_root   <= {i_root[SW-2:0], ge};
            o_rad    <= {i_rad[2*SW-3:0], 2'b00};
            o_region <= i_region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

endmodule

`default_nettype wire

@@ sv/point_segment_distance_3d.sv @@
// Top level of the point-to-segment distance block: front end, divider and
// square-root cell chains, output register with skid. Depends on psd_pkg,
// psd_front, psd_div_cell, psd_sqrt_cell.
//
// Usage: one input word holds a segment (two endpoints) and a query point.
// For each accepted word one result word comes out: the distance with
// FRAC_BITS fraction bits, truncated, and which part of the segment is
// nearest (first endpoint, second endpoint or interior).
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Throughput: one word per cycle while o_stall is low. The path runs through
// five front stages, one divider cell per quotient bit, one square-root cell
// per root bit and one output register.
// The whole pipe advances together; it holds only when the skid entry is
// full, so o_stall rises in the cycle after a stalled result backs up, and new
// words keep entering while a finished result waits.
// Reset clears all stage valid bits and the output/skid; no words are lost
// or duplicated across a receiver stall.
`default_nettype none

module point_segment_distance_3d import psd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_data
);

    localparam int RW   = 2*COORD_BITS + 2;
    localparam int QW   = 2*COORD_BITS + 2*FRAC_BITS + 2;
    localparam int SW   = QW / 2;
    localparam int SATW = ((SW > DIST_W) ? SW : DIST_W) + 1;

    logic en;
    logic r_out_v, r_skid_v;
    t_out r_out, r_skid;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // ---------------- divider chain
    logic          w_dv   [0:QW];
    logic [RW-1:0] w_drem [0:QW];
    logic [QW-1:0] w_dnq  [0:QW];
    logic [RW-1:0] w_ddiv [0:QW];
    t_region       w_dreg [0:QW];

    psd_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_valid  (w_dv[0]),
        .o_rem    (w_drem[0]),
        .o_nq     (w_dnq[0]),
        .o_div    (w_ddiv[0]),
        .o_region (w_dreg[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_div
        psd_div_cell #(
            .RW (RW),
            .QW (QW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (w_dv[g]),
            .i_rem    (w_drem[g]),
            .i_nq     (w_dnq[g]),
            .i_div    (w_ddiv[g]),
            .i_region (w_dreg[g]),
            .o_valid  (w_dv[g+1]),
            .o_rem    (w_drem[g+1]),
            .o_nq     (w_dnq[g+1]),
            .o_div    (w_ddiv[g+1]),
            .o_region (w_dreg[g+1])
        );
    end

    // ---------------- square-root chain
    logic            w_sv    [0:SW];
    logic [SW:0]     w_srem  [0:SW];
    logic [SW-1:0]   w_sroot [0:SW];
    logic [2*SW-1:0] w_srad  [0:SW];
    t_region         w_sreg  [0:SW];

    assign w_sv[0]    = w_dv[QW];
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = w_dnq[QW];
    assign w_sreg[0]  = w_dreg[QW];

    for (genvar g = 0; g < SW; g++) begin : g_sqrt
        psd_sqrt_cell #(
            .SW (SW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (w_sv[g]),
            .i_rem    (w_srem[g]),
            .i_root   (w_sroot[g]),
            .i_rad    (w_srad[g]),
            .i_region (w_sreg[g]),
            .o_valid  (w_sv[g+1]),
            .o_rem    (w_srem[g+1]),
            .o_root   (w_sroot[g+1]),
            .o_rad    (w_srad[g+1]),
            .o_region (w_sreg[g+1])
        );
    end

    // ---------------- result word with saturation
    logic [SATW-1:0] root_ext;
    t_out            res;

    always_comb begin
        root_ext           = SATW'(w_sroot[SW]);
        res.nearest_region = w_sreg[SW];
        if (root_ext > SATW'(DIST_MAX)) begin
            res.distance_q8 = DIST_MAX;
        end else begin
            res.distance_q8 = root_ext[DIST_W-1:0];
        end
    end

    // ---------------- output register and skid entry
    logic arrive;
    assign arrive = en && w_sv[SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_skid_v <= 1'b0;
            end
        end else if (arrive) begin
            if (r_out_v && i_stall) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (r_out_v && !i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (arrive) begin
            if (r_out_v && i_stall) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    // ---------------- checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds a word while the output register is empty");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv[0] |-> (w_drem[0] < w_ddiv[0]))
        else $error("divider entry remainder not below divisor: quotient overflow");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv[QW] |-> (w_drem[QW] < w_ddiv[QW]))
        else $error("divider exit remainder not below divisor");

endmodule

`default_nettype wire

@@ tb/sv/tb_point_segment_distance_3d.sv @@
// Testbench for point_segment_distance_3d: random and directed segment/point
// words, a self-contained distance predictor and an in-order result check.
// Depends on psd_pkg and the point_segment_distance_3d RTL.
`default_nettype none

module tb_point_segment_distance_3d;
    import psd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 81;
    localparam int CYC_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data = '0;
    logic o_stall, o_valid;
    t_out o_data;

    t_in  pending_words[$];
    t_out expected_dist[$];
    int   n_errors = 0;
    int   cyc = 0;
    bit   stim_done = 1'b0;
    int   hold_cycles = 0;
    bit   hold_done = 1'b0;
    int   quiet_lo = 600, quiet_hi = 900;

    point_segment_distance_3d u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Integer square root by bit trial
    function automatic logic [63:0] int_sqrt(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] clip_dist(logic [63:0] d);
        return (d > {39'd0, DIST_MAX}) ? DIST_MAX : d[DIST_W-1:0];
    endfunction

    // Expected distance and nearest part for one word
    function automatic t_out seg_distance(t_in w);
        longint x1, y1, z1, x2, y2, z2, x0, y0, z0;
        longint a, b, c, vx, vy, vz, r2, t, fx, fy, fz, dx, dy, dz;
        logic [127:0] f2, q;
        t_out o;
        x1 = w.seg_start_x; y1 = w.seg_start_y; z1 = w.seg_start_z;
        x2 = w.seg_end_x;   y2 = w.seg_end_y;   z2 = w.seg_end_z;
        x0 = w.point_x;     y0 = w.point_y;     z0 = w.point_z;
        a = x2 - x1; b = y2 - y1; c = z2 - z1;
        vx = x1 - x0; vy = y1 - y0; vz = z1 - z0;
        r2 = a*a + b*b + c*c;
        t = -(a*vx + b*vy + c*vz);
        if (t < 0 || r2 == 0 || t > r2) begin
            if (t < 0 || r2 == 0) begin
                dx = vx; dy = vy; dz = vz;
                o.nearest_region = REGION_START;
            end else begin
                dx = x2 - x0; dy = y2 - y0; dz = z2 - z0;
                o.nearest_region = REGION_END;
            end
            q = 128'(dx*dx + dy*dy + dz*dz) << (2*FRAC_BITS_DEF);
        end else begin
            fx = b*vz - c*vy;
            fy = c*vx - a*vz;
            fz = a*vy - b*vx;
            // cross squares can pass 64 bits
            f2 = 128'(fx) * 128'(fx) + 128'(fy) * 128'(fy) + 128'(fz) * 128'(fz);
            q = (f2 << (2*FRAC_BITS_DEF)) / 128'(r2);
            o.nearest_region = REGION_MID;
        end
        o.distance_q8 = clip_dist(int_sqrt(q));
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cyc);
        n_errors++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in rand_word();
        t_in w;
        w.seg_start_x = rand_coord(); w.seg_start_y = rand_coord();
        w.seg_start_z = rand_coord(); w.seg_end_x = rand_coord();
        w.seg_end_y = rand_coord();   w.seg_end_z = rand_coord();
        case ($urandom_range(0, 3))
            // point near the segment interior
            0: begin
                w.point_x = (w.seg_start_x >>> 1) + (w.seg_end_x >>> 1) + 16'($urandom_range(0, 200));
                w.point_y = (w.seg_start_y >>> 1) + (w.seg_end_y >>> 1) - 16'($urandom_range(0, 200));
                w.point_z = (w.seg_start_z >>> 1) + (w.seg_end_z >>> 1);
            end
            1: begin
                w.seg_end_x = w.seg_start_x; w.seg_end_y = w.seg_start_y;
                w.seg_end_z = w.seg_start_z;
                w.point_x = rand_coord(); w.point_y = rand_coord(); w.point_z = rand_coord();
            end
            default: begin
                w.point_x = rand_coord(); w.point_y = rand_coord(); w.point_z = rand_coord();
            end
        endcase
        return w;
    endfunction

    function automatic t_in mk(int sx, int sy, int sz, int ex, int ey, int ez,
                               int px, int py, int pz);
        t_in w;
        w.seg_start_x = 16'(sx); w.seg_start_y = 16'(sy); w.seg_start_z = 16'(sz);
        w.seg_end_x = 16'(ex);   w.seg_end_y = 16'(ey);   w.seg_end_z = 16'(ez);
        w.point_x = 16'(px);     w.point_y = 16'(py);     w.point_z = 16'(pz);
        return w;
    endfunction

    // Fill the pending queue: directed words, then random ones
    initial begin
        pending_words.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(mk(5, 5, 5, 5, 5, 5, -3, 7, 1));
        pending_words.push_back(mk(0, 0, 0, 10, 0, 0, -4, 3, 0));
        pending_words.push_back(mk(0, 0, 0, 10, 0, 0, 14, 3, 0));
        pending_words.push_back(mk(0, 0, 0, 10, 0, 0, 5, 3, 4));
        pending_words.push_back(mk(0, 0, 0, 10, 0, 0, 0, 3, 0));
        pending_words.push_back(mk(0, 0, 0, 10, 0, 0, 10, 3, 0));
        pending_words.push_back(mk(0, 0, 0, 10, 0, 0, 5, 0, 0));
        pending_words.push_back(mk(1, 2, 3, 4, 6, 8, 2, 2, 2));
        pending_words.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                                   32767, -32768, 32767));
        pending_words.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                                   -32768, -32768, -32768));
        pending_words.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                                   32767, 32767, 32767));
        pending_words.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                                   -32768, -32768, -32768));
        pending_words.push_back(mk(-32768, 0, 0, 32767, 0, 0, 0, 32767, -32768));
        pending_words.push_back(mk(-32768, -32768, 0, -32768, 32767, 0, 32767, 0, 32767));
        pending_words.push_back(mk(-1, -1, -1, 1, 1, 1, 0, 0, 1));
        pending_words.push_back(mk(0, 0, 0, 3, 4, 0, 3, 4, 0));
        pending_words.push_back(mk(-21845, 21845, -1, 21845, -21845, 1, 0, 0, 0));
        for (int k = 0; k < 1800; k++) pending_words.push_back(rand_word());
    end

    // Driver: offers the next pending word, holds it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (!i_valid || !o_stall) begin
                if (pending_words.size() != 0 &&
                    ((cyc > 300 && cyc < 700) || $urandom_range(0, 99) >= 27)) begin
                    i_data  <= pending_words.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                    if (pending_words.size() == 0) stim_done <= 1'b1;
                end
            end
        end
    end

    // Predict every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) expected_dist.push_back(seg_distance(i_data));
    end

    // Receiver stall: random, one long hold-off, one quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!hold_done && cyc >= 1000) begin
            i_stall <= (hold_cycles != 300);
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == 300) begin
                hold_done <= 1'b1;
            end
        end else if (cyc > quiet_lo && cyc < quiet_hi) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 27);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_dist.size() == 0) begin
                report_mismatch("unexpected result, distance", o_data.distance_q8, -1);
            end else begin
                want = expected_dist.pop_front();
                if (o_data.distance_q8 !== want.distance_q8)
                    report_mismatch("distance_q8", o_data.distance_q8, want.distance_q8);
                if (o_data.nearest_region !== want.nearest_region)
                    report_mismatch("nearest_region", o_data.nearest_region,
                                    want.nearest_region);
            end
        end
    end

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYC_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Reset, then wait for the stream to drain
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_dist.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && expected_dist.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
